### sv/assert_macros.svh
// Assertion macros used by the sort engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that cons holds in every cycle in which ante holds.
`define QSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qse assertion failed");
// Check that expr never holds.
`define QSE_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("qse assertion failed");
`else
`define QSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QSE_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### sv/qse_pkg.sv
// Shared types and constants of the quicksort engine.
package qse_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int MODE_W          = 2;

  // Register index decode (byte address bit 2 selects the register).
  localparam logic REG_COMPARE_MODE = 1'b0;

  // Bits of the compare mode.
  localparam int MODE_SIGNED_BIT = 0;
  localparam int MODE_DESC_BIT   = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_INIT,
    ST_POP,
    ST_POP_DATA,
    ST_PIVOT,
    ST_A_CMP,
    ST_B_CMP,
    ST_FINISH,
    ST_PUSH2,
    ST_EMIT_RD,
    ST_EMIT_LD
  } qse_state_t;

  typedef struct packed {
    logic precedes;
    logic follows;
  } qse_order_t;

endpackage

### sv/qse_cmp.sv
// Shared order comparator: ranks both operands under the compare mode.
module qse_cmp import qse_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  input  logic [MODE_W-1:0]      mode,
  output qse_order_t             order
);

  logic [VALUE_WIDTH-1:0] flip;
  logic [VALUE_WIDTH-1:0] rank_a;
  logic [VALUE_WIDTH-1:0] rank_b;

  // Flip the sign bit for signed order, invert everything for descending.
  always_comb begin
    flip = '0;
    flip[VALUE_WIDTH-1] = mode[MODE_SIGNED_BIT];
    rank_a = a ^ flip;
    rank_b = b ^ flip;
    if (mode[MODE_DESC_BIT]) begin
      rank_a = ~rank_a;
      rank_b = ~rank_b;
    end
    order.precedes = rank_a < rank_b;
    order.follows  = rank_a > rank_b;
  end

endmodule

### sv/qse_ctrl.sv
// Sort sequencer: element store, range stack, partition control, result register.
`include "assert_macros.svh"
module qse_ctrl import qse_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_sorted_value,
  output logic              out_final_res,
  output logic              out_dropped
);

  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int SW        = AW + CW;
  localparam int STACK_MAX = CAPACITY / 2;

  qse_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] store_mem [CAPACITY];
  logic [SW-1:0]          stack_mem [CAPACITY];

  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [SW-1:0]          stk_data_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic [AW-1:0] right_r, right_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] pivot_r, pivot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic                   stk_we, stk_re;
  logic [AW-1:0]          stk_wa, stk_ra;
  logic [SW-1:0]          stk_wd;

  logic [VALUE_WIDTH-1:0] in_ext;
  logic [DATA_W-1:0]      out_word;
  logic [AW-1:0]          left_inc, right_dec;
  logic [CW-1:0]          sp_dec;
  qse_order_t             order;

  generate
    if (VALUE_WIDTH > DATA_W) begin : g_wide
      assign in_ext   = {{(VALUE_WIDTH - DATA_W){1'b0}}, in_value};
      assign out_word = rd_data_r[DATA_W-1:0];
    end else if (VALUE_WIDTH == DATA_W) begin : g_equal
      assign in_ext   = in_value;
      assign out_word = rd_data_r;
    end else begin : g_narrow
      assign in_ext   = in_value[VALUE_WIDTH-1:0];
      assign out_word = {{(DATA_W - VALUE_WIDTH){1'b0}}, rd_data_r};
    end
  endgenerate

  qse_cmp #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
    .a     (rd_data_r),
    .b     (pivot_r),
    .mode  (mode),
    .order (order)
  );

  assign left_inc  = left_r + AW'(1);
  assign right_dec = right_r - AW'(1);
  assign sp_dec    = sp_r - CW'(1);

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_data_r;
  assign out_final_res    = out_final_r;
  assign out_dropped      = out_drop_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_data_r <= stack_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      drop_r      <= 1'b0;
      sp_r        <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      left_r      <= '0;
      right_r     <= '0;
      k_r         <= '0;
      pivot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      drop_r      <= drop_nxt;
      sp_r        <= sp_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      k_r         <= k_nxt;
      pivot_r     <= pivot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_final_r <= out_final_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    drop_nxt  = drop_r;
    sp_nxt    = sp_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    k_nxt     = k_r;
    pivot_nxt = pivot_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_final_nxt = out_final_r;
    out_drop_nxt  = out_drop_r;

    mem_we = 1'b0;
    mem_wa = left_r;
    mem_wd = rd_data_r;
    mem_re = 1'b0;
    mem_ra = right_dec;
    stk_we = 1'b0;
    stk_wa = sp_r[AW-1:0];
    stk_wd = {lo_r, CW'(left_r)};
    stk_re = 1'b0;
    stk_ra = sp_dec[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (count_r < CW'(CAPACITY)) begin
            mem_we    = 1'b1;
            mem_wa    = count_r[AW-1:0];
            mem_wd    = in_ext;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            drop_nxt  = ovf_r || (count_r == CW'(CAPACITY));
            state_nxt = ST_SORT_INIT;
          end
        end
      end
      ST_SORT_INIT: begin
        sp_nxt = '0;
        if (count_r >= CW'(2)) begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = {AW'(0), count_r};
          sp_nxt = CW'(1);
        end
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          sp_nxt    = sp_dec;
          stk_re    = 1'b1;
          state_nxt = ST_POP_DATA;
        end
      end
      ST_POP_DATA: begin
        lo_nxt = stk_data_r[SW-1:CW];
        hi_nxt = stk_data_r[CW-1:0];
        if (CW'(stk_data_r[SW-1:CW]) + CW'(1) >= stk_data_r[CW-1:0]) begin
          state_nxt = ST_POP;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = stk_data_r[SW-1:CW];
          state_nxt = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        // Hole opens at the low end; scan down from the top of the range.
        pivot_nxt = rd_data_r;
        left_nxt  = lo_r;
        right_nxt = AW'(hi_r - CW'(1));
        mem_re    = 1'b1;
        mem_ra    = AW'(hi_r - CW'(1));
        state_nxt = ST_A_CMP;
      end
      ST_A_CMP: begin
        if (!order.precedes) begin
          right_nxt = right_dec;
          if (right_dec == left_r) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_re = 1'b1;
            mem_ra = right_dec;
          end
        end else begin
          // Fill the hole at left, move the hole to right.
          mem_we   = 1'b1;
          mem_wa   = left_r;
          left_nxt = left_inc;
          if (left_inc == right_r) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_re    = 1'b1;
            mem_ra    = left_inc;
            state_nxt = ST_B_CMP;
          end
        end
      end
      ST_B_CMP: begin
        if (!order.follows) begin
          left_nxt = left_inc;
          if (left_inc == right_r) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_re = 1'b1;
            mem_ra = left_inc;
          end
        end else begin
          // Fill the hole at right, move the hole to left.
          mem_we    = 1'b1;
          mem_wa    = right_r;
          right_nxt = right_dec;
          if (right_dec == left_r) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_re    = 1'b1;
            mem_ra    = right_dec;
            state_nxt = ST_A_CMP;
          end
        end
      end
      ST_FINISH: begin
        mem_we = 1'b1;
        mem_wa = left_r;
        mem_wd = pivot_r;
        if (CW'(left_r) - CW'(lo_r) >= CW'(2)) begin
          stk_we = 1'b1;
          stk_wd = {lo_r, CW'(left_r)};
          sp_nxt = sp_r + CW'(1);
        end
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (hi_r - CW'(left_r) > CW'(2)) begin
          stk_we = 1'b1;
          stk_wd = {left_inc, hi_r};
          sp_nxt = sp_r + CW'(1);
        end
        state_nxt = ST_POP;
      end
      ST_EMIT_RD: begin
        if (!out_valid_r || !out_stall) begin
          mem_re    = 1'b1;
          mem_ra    = k_r;
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = out_word;
        out_final_nxt = (CW'(k_r) + CW'(1) == count_r);
        out_drop_nxt  = drop_r;
        if (CW'(k_r) + CW'(1) == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `QSE_ASSERT_NEVER(a_stack_bound, clk, rst_n, sp_r > CW'(STACK_MAX))
  `QSE_ASSERT_IMP(a_scan_order, clk, rst_n,
    (state_r == ST_A_CMP || state_r == ST_B_CMP), left_r < right_r)
  `QSE_ASSERT_IMP(a_out_free, clk, rst_n, state_r == ST_EMIT_LD, !out_valid_r)
  `QSE_ASSERT_IMP(a_emit_range, clk, rst_n,
    (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD), CW'(k_r) < count_r)

endmodule

### sv/quicksort_engine.sv
// Top level of the quicksort engine: configuration port and sort sequencer.
//
// Usage:
//  - Input channel (in_valid/in_stall, in_value, in_last): one value per item,
//    accepted in one cycle each while the engine is loading. An item with
//    in_last high closes the set; the engine then sorts and stalls input.
//  - Up to CAPACITY values are kept; later values of the same set are
//    discarded, and every result of that set carries out_dropped high.
//  - Sorting runs on one comparator and a one-read, one-write element store.
//    Each range is popped from the stack and partitioned about its first
//    value by compare steps; each part of two or more values is pushed back.
//  - Results (out_valid/out_stall, out_sorted_value, out_final_res,
//    out_dropped) leave in sorted order, each read from the store and then
//    held in an output register; out_final_res marks the last one.
//  - A stalled result holds in the output register; the sequencer waits.
//    Input is accepted again once the last result is in the register.
//  - compare_mode (byte address 0) selects signed/unsigned and direction;
//    write it only while the engine is idle.
//  - Synchronous reset clears the mode, the fill count and the output valid.
module quicksort_engine import qse_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_sorted_value,
  output logic                  out_final_res,
  output logic                  out_dropped
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              cfg_wr;
  logic              cfg_sel_mode;

  // Register select is byte address bit 2; everything else decodes to nothing.
  assign cfg_pready   = 1'b1;
  assign cfg_sel_mode = (cfg_paddr[2] == REG_COMPARE_MODE);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && cfg_sel_mode) begin
      mode_nxt = cfg_pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Read back the mode; unused addresses read as zero.
  assign cfg_prdata = cfg_sel_mode ? CFG_DATA_W'(mode_r) : '0;

  qse_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .mode             (mode_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_dropped      (out_dropped)
  );

endmodule

### dv/qse_tb_pkg.sv
// Sort checker class for the quicksort engine testbench.
`timescale 1ns / 100ps
package qse_tb_pkg;
  import qse_pkg::*;

  typedef enum bit [MODE_W-1:0] {
    MODE_UNS_ASC  = 2'd0,
    MODE_SGN_ASC  = 2'd1,
    MODE_UNS_DESC = 2'd2,
    MODE_SGN_DESC = 2'd3
  } sort_mode_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              final_res;
    logic              dropped;
  } sorted_item_t;

  class sort_checker;
    sort_mode_t        mode;
    logic [DATA_W-1:0] held_set[$];
    bit                overflowed;
    sorted_item_t      sorted_due[$];
    int                errors;
    int                sets_closed;
    int                overflow_sets;
    int                results_matched;

    function new();
      mode = MODE_UNS_ASC;
      overflowed = 1'b0;
      errors = 0;
      sets_closed = 0;
      overflow_sets = 0;
      results_matched = 0;
    endfunction

    function void set_mode(sort_mode_t m);
      mode = m;
    endfunction

    // Map a value onto an unsigned key whose plain order is the mode's order.
    function logic [DATA_W-1:0] order_key(logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] k;
      k = v;
      if (mode[MODE_SIGNED_BIT]) k[DATA_W-1] = ~k[DATA_W-1];
      if (mode[MODE_DESC_BIT]) k = ~k;
      return k;
    endfunction

    // The key is a bijection of the value, so ties are identical values and
    // any correct sort yields exactly what the partition sort leaves behind.
    function void sort_held_set();
      logic [DATA_W-1:0] v;
      int                j;
      sorted_item_t      r;
      for (int i = 1; i < held_set.size(); i++) begin
        v = held_set[i];
        j = i - 1;
        while (j >= 0 && order_key(held_set[j]) > order_key(v)) begin
          held_set[j+1] = held_set[j];
          j--;
        end
        held_set[j+1] = v;
      end
      foreach (held_set[i]) begin
        r.value = held_set[i];
        r.final_res = (i == held_set.size() - 1);
        r.dropped = overflowed;
        sorted_due.push_back(r);
      end
      sets_closed++;
      if (overflowed) overflow_sets++;
      held_set.delete();
      overflowed = 1'b0;
    endfunction

    // Note one accepted input item.
    function void take_value(logic [DATA_W-1:0] v, logic last);
      if (held_set.size() < CAPACITY_DEF) held_set.push_back(v);
      else overflowed = 1'b1;
      if (last) sort_held_set();
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void match_result(logic [DATA_W-1:0] v, logic fin, logic drp);
      sorted_item_t e;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result value %h final %b dropped %b",
                 $time, v, fin, drp);
        errors++;
        return;
      end
      e = sorted_due.pop_front();
      if (v !== e.value) begin
        $display("%0t: sorted_value expected %h got %h", $time, e.value, v);
        errors++;
      end
      if (fin !== e.final_res) begin
        $display("%0t: final_res expected %b got %b", $time, e.final_res, fin);
        errors++;
      end
      if (drp !== e.dropped) begin
        $display("%0t: dropped expected %b got %b", $time, e.dropped, drp);
        errors++;
      end
      results_matched++;
    endfunction
  endclass

endpackage

### dv/tb.sv
// Testbench top for the quicksort engine: stimulus, handshakes and checks.
`timescale 1ns / 100ps
module tb;
  import qse_pkg::*;
  import qse_tb_pkg::*;

  localparam int ITEM_TARGET  = 270;
  localparam int IDLE_LIMIT   = 40000;
  localparam int SETTLE_WAIT  = 6;
  localparam int END_WAIT     = 20;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE   = {REG_COMPARE_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = {~REG_COMPARE_MODE, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_value = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_sorted_value;
  logic                  out_final_res;
  logic                  out_dropped;

  sort_checker sorter = new();

  // Quiet phases run with no gaps and no stalls on either side.
  bit                quiet = 1'b0;
  int                items_sent = 0;
  logic [DATA_W-1:0] recent_value = '0;

  quicksort_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_dropped      (out_dropped)
  );

  always #1 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Mix full-range values with small ones, extremes and repeats so that
  // signed/unsigned boundaries and equal keys show up often.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, 15);
      1: v = {1'b1, 31'($urandom_range(0, 15))};
      2: v = {1'b0, {(DATA_W-1){1'b1}}} - $urandom_range(0, 3);
      3: v = {DATA_W{1'b1}} - $urandom_range(0, 3);
      4: v = recent_value;
      default: v = $urandom;
    endcase
    recent_value = v;
    return v;
  endfunction

  // Write one register: setup cycle, then access until pready.
  task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Set the compare mode; upper data bits carry noise the block must ignore.
  task automatic set_compare_mode(sort_mode_t m);
    reg_write(ADDR_MODE, {30'($urandom), m});
    sorter.set_mode(m);
  endtask

  // Offer one item and hold it until accepted. Valid stays high afterwards so
  // that a back-to-back item needs no second assignment in the same step.
  task automatic send_item(logic [DATA_W-1:0] v, logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sorter.take_value(v, last);
    items_sent++;
  endtask

  task automatic send_set(int size);
    for (int i = 0; i < size; i++) send_item(pick_value(), i == size - 1);
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorter.sorted_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic send_extremes_set();
    send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
    send_item('0, 1'b0);
    send_item({DATA_W{1'b1}}, 1'b0);
    send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
    send_item(1, 1'b0);
    send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
  endtask

  // Result side: stall in runs of random length, sometimes long.
  int stall_run = 0;
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= pick_gap();
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sorter.match_result(out_sorted_value, out_final_res, out_dropped);
  end

  // Watchdog: end the run if nothing moves for too long. The longest quiet
  // span is a worst-case 64-element sort, far below the limit.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("FAIL quicksort_engine");
    $finish;
  end

  initial begin
    sort_mode_t m;
    int         size;
    bit         first_random;
    // Hold reset from time zero, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a single-element set, then the signed/unsigned boundary
    // values with a duplicate under every compare mode. An out-of-range
    // register write goes in between, just before the next mode is written.
    set_compare_mode(MODE_UNS_ASC);
    send_item(32'h5A5A_A5A5, 1'b1);
    send_extremes_set();
    drain();
    reg_write(ADDR_UNUSED, {CFG_DATA_W{1'b1}});
    for (int k = MODE_SGN_ASC; k <= MODE_SGN_DESC; k++) begin
      set_compare_mode(sort_mode_t'(k));
      send_extremes_set();
      drain();
    end

    // Random phases: new mode, a few sets, mostly small. Open with a set
    // that fills the store exactly and then loses its closing item.
    first_random = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      m = sort_mode_t'($urandom_range(0, 3));
      set_compare_mode(m);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        if (first_random) size = CAPACITY_DEF + 1;
        else if ($urandom_range(0, 11) == 0) size = $urandom_range(40, CAPACITY_DEF + 4);
        else size = $urandom_range(1, 10);
        first_random = 1'b0;
        send_set(size);
      end
      drain();
      quiet = 1'b0;
    end

    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d items in %0d sets (%0d past capacity), all four compare modes.",
             items_sent, sorter.sets_closed, sorter.overflow_sets);
    $display("Checked %0d sorted results, %0d mismatches.",
             sorter.results_matched, sorter.errors);
    if (sorter.errors == 0 && sorter.sorted_due.size() == 0)
      $display("PASS quicksort_engine");
    else
      $display("FAIL quicksort_engine");
    $finish;
  end

endmodule
